/* rtl/core/odc_pkg.sv */
// Shared types, constants and angle helpers for the obstacle-avoiding drive controller.
`timescale 1ns / 1ps

package odc_pkg;

  localparam int NUM_HEADINGS = 4;
  localparam int FILTER_LIMIT = 3;
  localparam int NUM_CARD     = 4;
  localparam int SNAP_COUNT   = (NUM_HEADINGS < NUM_CARD) ? NUM_HEADINGS : NUM_CARD;

  localparam int DIST_W  = 10;
  localparam int POWER_W = 8;
  localparam int TOL_W   = 11;
  localparam int ANGLE_W = 12;
  localparam int INDEX_W = 3;
  localparam int COUNT_W = 3;

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic signed [ANGLE_W:0]   angle_wide_t;

  localparam angle_wide_t ANGLE_HALF   = 13'sd1800;
  localparam angle_wide_t ANGLE_FULL   = 13'sd3600;
  localparam angle_wide_t QUARTER_TURN = 13'sd900;
  localparam logic [ANGLE_W-1:0] SNAP_WINDOW = 12'd450;
  localparam logic [COUNT_W-1:0] NEAR_MAX    = 3'd7;

  typedef enum logic [INDEX_W-1:0] {
    REG_CRUISE_PWR   = 3'd0,
    REG_SPIN_PWR     = 3'd1,
    REG_NEAR_THRESH  = 3'd2,
    REG_ANGLE_TOL    = 3'd3,
    REG_CARDINAL_0   = 3'd4,
    REG_CARDINAL_1   = 3'd5,
    REG_CARDINAL_2   = 3'd6,
    REG_CARDINAL_3   = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [POWER_W-1:0]    cruise_pwr;
    logic [POWER_W-1:0]    spin_pwr;
    logic [DIST_W-1:0]     near_thresh;
    logic [TOL_W-1:0]      angle_tolerance;
    angle_t [NUM_CARD-1:0] cardinal;
  } cfg_t;

  localparam logic [POWER_W-1:0] CRUISE_PWR_RST  = 8'd150;
  localparam logic [POWER_W-1:0] SPIN_PWR_RST    = 8'd120;
  localparam logic [DIST_W-1:0]  NEAR_THRESH_RST = 10'd30;
  localparam logic [TOL_W-1:0]   ANGLE_TOL_RST   = 11'd50;
  localparam angle_t CARDINAL_0_RST = 12'sd0;
  localparam angle_t CARDINAL_1_RST = 12'sd900;
  localparam angle_t CARDINAL_2_RST = -12'sd1800;
  localparam angle_t CARDINAL_3_RST = -12'sd900;

  function automatic angle_wide_t widen(input angle_t a);
    return $signed({a[ANGLE_W-1], a});
  endfunction

  // fold a difference or sum within one turn of range back into [-1800,1800)
  function automatic angle_t wrap_angle(input angle_wide_t a);
    angle_wide_t r;
    if (a >= ANGLE_HALF) begin
      r = a - ANGLE_FULL;
    end else if (a < -ANGLE_HALF) begin
      r = a + ANGLE_FULL;
    end else begin
      r = a;
    end
    return $signed(r[ANGLE_W-1:0]);
  endfunction

  function automatic logic [ANGLE_W-1:0] abs_angle(input angle_t a);
    angle_t n;
    n = -a;
    return a[ANGLE_W-1] ? n : a;
  endfunction

endpackage

/* rtl/core/obstacle_avoid_drive_controller.sv */
// Top level: input register, drive/turn step logic and result register.
//
//   channel  | handshake           | payload
//   ---------+---------------------+------------------------------------------------
//   in       | in_valid / in_stall | front_dist, left_dist, right_dist, heading
//   out      | out_valid/out_stall | motor pins and duty, drive_mode, goal_heading,
//            |                     | obstacle_seen, turn_done
//   config   | wr_en               | wr_index, wr_data
//
// One request per cycle while in_stall is low. The input register loads at the
// accepting edge, and the result register loads from it whenever it is empty or
// out_stall is low, so each result has passed through both registers.
// Reset (synchronous) clears both stages, mode, near count and target, and loads
// the register defaults.
// out_stall holds the result register; in_stall rises only when both stages are
// full and the result is held.
`timescale 1ns / 1ps

module obstacle_avoid_drive_controller (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [odc_pkg::DIST_W-1:0]    front_dist,
  input  logic [odc_pkg::DIST_W-1:0]    left_dist,
  input  logic [odc_pkg::DIST_W-1:0]    right_dist,
  input  logic signed [odc_pkg::ANGLE_W-1:0] heading,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          left_pin_a,
  output logic                          left_pin_b,
  output logic [odc_pkg::POWER_W-1:0]   left_duty,
  output logic                          right_pin_a,
  output logic                          right_pin_b,
  output logic [odc_pkg::POWER_W-1:0]   right_duty,
  output logic signed [1:0]             drive_mode,
  output logic signed [odc_pkg::ANGLE_W-1:0] goal_heading,
  output logic                          obstacle_seen,
  output logic                          turn_done,
  input  logic                          wr_en,
  input  logic [odc_pkg::INDEX_W-1:0]   wr_index,
  input  logic [odc_pkg::ANGLE_W-1:0]   wr_data
);

  typedef enum logic [1:0] {
    MODE_STRAIGHT = 2'b00,
    MODE_RIGHT    = 2'b01,
    MODE_LEFT     = 2'b11
  } mode_t;

  odc_pkg::cfg_t cfg;

  logic                        s1_valid;
  logic [odc_pkg::DIST_W-1:0]  s1_front;
  logic [odc_pkg::DIST_W-1:0]  s1_left;
  logic [odc_pkg::DIST_W-1:0]  s1_right;
  odc_pkg::angle_t             s1_heading;

  mode_t                        mode;
  mode_t                        mode_next;
  logic [odc_pkg::COUNT_W-1:0]  near_cnt;
  logic [odc_pkg::COUNT_W-1:0]  near_cnt_next;
  logic [odc_pkg::COUNT_W-1:0]  near_inc;
  odc_pkg::angle_t              target;
  odc_pkg::angle_t              target_next;
  odc_pkg::angle_t              snap_target;
  odc_pkg::angle_t              err_wrap;
  logic                         turn_right;
  logic                         advance;

  logic                         left_pin_a_next, left_pin_b_next;
  logic                         right_pin_a_next, right_pin_b_next;
  logic [odc_pkg::POWER_W-1:0]  left_duty_next, right_duty_next;
  logic                         obstacle_seen_next, turn_done_next;

  odc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  assign turn_right = s1_right > s1_left;

  odc_target u_target (
    .heading    (s1_heading),
    .turn_right (turn_right),
    .cardinal   (cfg.cardinal),
    .target     (snap_target)
  );

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;

  assign err_wrap = odc_pkg::wrap_angle(odc_pkg::widen(s1_heading) - odc_pkg::widen(target));
  assign near_inc = (near_cnt == odc_pkg::NEAR_MAX) ? near_cnt : near_cnt + 3'd1;

  always_comb begin
    mode_next          = mode;
    near_cnt_next      = near_cnt;
    target_next        = target;
    obstacle_seen_next = 1'b0;
    turn_done_next     = 1'b0;
    left_pin_a_next    = 1'b1;
    left_pin_b_next    = 1'b1;
    left_duty_next     = '0;
    right_pin_a_next   = 1'b1;
    right_pin_b_next   = 1'b1;
    right_duty_next    = '0;
    unique case (mode)
      MODE_STRAIGHT: begin
        near_cnt_next = (s1_front < cfg.near_thresh) ? near_inc : '0;
        if (near_cnt_next > odc_pkg::COUNT_W'(odc_pkg::FILTER_LIMIT)) begin
          near_cnt_next      = '0;
          obstacle_seen_next = 1'b1;
          target_next        = snap_target;
          mode_next          = turn_right ? MODE_RIGHT : MODE_LEFT;
        end else if (cfg.cruise_pwr != '0) begin
          left_pin_a_next  = 1'b0;
          left_pin_b_next  = 1'b1;
          left_duty_next   = cfg.cruise_pwr;
          right_pin_a_next = 1'b1;
          right_pin_b_next = 1'b0;
          right_duty_next  = cfg.cruise_pwr;
        end
      end
      MODE_RIGHT, MODE_LEFT: begin
        if (odc_pkg::abs_angle(err_wrap) < {1'b0, cfg.angle_tolerance}) begin
          turn_done_next = 1'b1;
          mode_next      = MODE_STRAIGHT;
        end else if (cfg.spin_pwr != '0) begin
          // spin in place: right turn drives left forward, right reverse
          left_pin_a_next  = (mode == MODE_LEFT);
          left_pin_b_next  = (mode == MODE_RIGHT);
          left_duty_next   = cfg.spin_pwr;
          right_pin_a_next = (mode == MODE_LEFT);
          right_pin_b_next = (mode == MODE_RIGHT);
          right_duty_next  = cfg.spin_pwr;
        end
      end
      default: begin
        mode_next = MODE_STRAIGHT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_front   <= front_dist;
      s1_left    <= left_dist;
      s1_right   <= right_dist;
      s1_heading <= heading;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_STRAIGHT;
      near_cnt  <= '0;
      target    <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        mode          <= mode_next;
        near_cnt      <= near_cnt_next;
        target        <= target_next;
        left_pin_a    <= left_pin_a_next;
        left_pin_b    <= left_pin_b_next;
        left_duty     <= left_duty_next;
        right_pin_a   <= right_pin_a_next;
        right_pin_b   <= right_pin_b_next;
        right_duty    <= right_duty_next;
        drive_mode    <= mode_next;
        goal_heading  <= target_next;
        obstacle_seen <= obstacle_seen_next;
        turn_done     <= turn_done_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while result register free");

  a_events_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(obstacle_seen && turn_done))
    else $error("obstacle and turn finish in one result");

  a_seen_starts_turn: assert property (@(posedge clk) disable iff (rst)
    (out_valid && obstacle_seen) |-> (drive_mode != 2'sd0 && left_duty == '0 && right_duty == '0))
    else $error("obstacle result without stop and turn");

  a_done_goes_straight: assert property (@(posedge clk) disable iff (rst)
    (out_valid && turn_done) |-> (drive_mode == 2'sd0 && left_duty == '0 && right_duty == '0))
    else $error("turn finish without stop and straight mode");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    (mode != MODE_STRAIGHT) |-> (near_cnt <= odc_pkg::COUNT_W'(odc_pkg::FILTER_LIMIT)))
    else $error("near count above limit during a turn");
`endif

endmodule

/* rtl/core/odc_cfg_regs.sv */
// Configuration register file with reset defaults.
`timescale 1ns / 1ps

module odc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [odc_pkg::INDEX_W-1:0]   wr_index,
  input  logic [odc_pkg::ANGLE_W-1:0]   wr_data,
  output odc_pkg::cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cruise_pwr      <= odc_pkg::CRUISE_PWR_RST;
      cfg.spin_pwr        <= odc_pkg::SPIN_PWR_RST;
      cfg.near_thresh     <= odc_pkg::NEAR_THRESH_RST;
      cfg.angle_tolerance <= odc_pkg::ANGLE_TOL_RST;
      cfg.cardinal[0]     <= odc_pkg::CARDINAL_0_RST;
      cfg.cardinal[1]     <= odc_pkg::CARDINAL_1_RST;
      cfg.cardinal[2]     <= odc_pkg::CARDINAL_2_RST;
      cfg.cardinal[3]     <= odc_pkg::CARDINAL_3_RST;
    end else if (wr_en) begin
      unique case (odc_pkg::reg_index_t'(wr_index))
        odc_pkg::REG_CRUISE_PWR:  cfg.cruise_pwr <= wr_data[odc_pkg::POWER_W-1:0];
        odc_pkg::REG_SPIN_PWR:    cfg.spin_pwr <= wr_data[odc_pkg::POWER_W-1:0];
        odc_pkg::REG_NEAR_THRESH: cfg.near_thresh <= wr_data[odc_pkg::DIST_W-1:0];
        odc_pkg::REG_ANGLE_TOL:   cfg.angle_tolerance <= wr_data[odc_pkg::TOL_W-1:0];
        odc_pkg::REG_CARDINAL_0:  cfg.cardinal[0] <= $signed(wr_data);
        odc_pkg::REG_CARDINAL_1:  cfg.cardinal[1] <= $signed(wr_data);
        odc_pkg::REG_CARDINAL_2:  cfg.cardinal[2] <= $signed(wr_data);
        odc_pkg::REG_CARDINAL_3:  cfg.cardinal[3] <= $signed(wr_data);
        default: begin
        end
      endcase
    end
  end

endmodule

/* rtl/core/odc_target.sv */
// New turn target: heading plus or minus a quarter turn, snapped to a cardinal heading within the snap window.
`timescale 1ns / 1ps

module odc_target (
  input  odc_pkg::angle_t                      heading,
  input  logic                                 turn_right,
  input  odc_pkg::angle_t [odc_pkg::NUM_CARD-1:0] cardinal,
  output odc_pkg::angle_t                      target
);

  odc_pkg::angle_t      base;
  odc_pkg::angle_wide_t h_wide;
  odc_pkg::angle_t      diff [odc_pkg::NUM_CARD];
  logic [odc_pkg::NUM_CARD-1:0] hit;

  always_comb begin
    h_wide = odc_pkg::widen(heading);
    if (turn_right) begin
      base = odc_pkg::wrap_angle(h_wide + odc_pkg::QUARTER_TURN);
    end else begin
      base = odc_pkg::wrap_angle(h_wide - odc_pkg::QUARTER_TURN);
    end
  end

  always_comb begin
    for (int i = 0; i < odc_pkg::NUM_CARD; i++) begin
      diff[i] = odc_pkg::wrap_angle(odc_pkg::widen(base) - odc_pkg::widen(cardinal[i]));
      hit[i]  = (i < odc_pkg::SNAP_COUNT) && (odc_pkg::abs_angle(diff[i]) <= odc_pkg::SNAP_WINDOW);
    end
  end

  // lowest index wins
  always_comb begin
    target = base;
    for (int i = odc_pkg::NUM_CARD - 1; i >= 0; i--) begin
      if (hit[i]) begin
        target = cardinal[i];
      end
    end
  end

endmodule

/* sim/tb_obstacle_avoid_drive_controller.sv */
// Self-checking testbench for the obstacle-avoiding drive controller.
`timescale 1ns / 1ps

module tb_obstacle_avoid_drive_controller;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int MAX_REPORTS   = 10;
  localparam int MODE_STRAIGHT = 0;
  localparam int MODE_RIGHT    = 1;
  localparam int MODE_LEFT     = -1;
  localparam int QUARTER_TENTHS = 900;
  localparam int HALF_TENTHS    = 1800;
  localparam int FULL_TENTHS    = 3600;
  localparam int SNAP_TENTHS    = 450;
  localparam int NEAR_SAT       = 7;

  typedef struct packed {
    logic [odc_pkg::DIST_W-1:0]         front;
    logic [odc_pkg::DIST_W-1:0]         left;
    logic [odc_pkg::DIST_W-1:0]         right;
    logic signed [odc_pkg::ANGLE_W-1:0] heading;
  } reading_t;

  typedef struct packed {
    logic                               left_pin_a;
    logic                               left_pin_b;
    logic [odc_pkg::POWER_W-1:0]        left_duty;
    logic                               right_pin_a;
    logic                               right_pin_b;
    logic [odc_pkg::POWER_W-1:0]        right_duty;
    logic signed [1:0]                  drive_mode;
    logic signed [odc_pkg::ANGLE_W-1:0] goal_heading;
    logic                               obstacle_seen;
    logic                               turn_done;
  } motor_cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [odc_pkg::DIST_W-1:0] front_dist = '0;
  logic [odc_pkg::DIST_W-1:0] left_dist = '0;
  logic [odc_pkg::DIST_W-1:0] right_dist = '0;
  logic signed [odc_pkg::ANGLE_W-1:0] heading = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic left_pin_a, left_pin_b, right_pin_a, right_pin_b;
  logic [odc_pkg::POWER_W-1:0] left_duty, right_duty;
  logic signed [1:0] drive_mode;
  logic signed [odc_pkg::ANGLE_W-1:0] goal_heading;
  logic obstacle_seen, turn_done;
  logic wr_en = 1'b0;
  logic [odc_pkg::INDEX_W-1:0] wr_index = '0;
  logic [odc_pkg::ANGLE_W-1:0] wr_data = '0;

  obstacle_avoid_drive_controller dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .front_dist(front_dist), .left_dist(left_dist), .right_dist(right_dist),
    .heading(heading),
    .out_valid(out_valid), .out_stall(out_stall),
    .left_pin_a(left_pin_a), .left_pin_b(left_pin_b), .left_duty(left_duty),
    .right_pin_a(right_pin_a), .right_pin_b(right_pin_b), .right_duty(right_duty),
    .drive_mode(drive_mode), .goal_heading(goal_heading),
    .obstacle_seen(obstacle_seen), .turn_done(turn_done),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  always #5 clk = ~clk;

  int fwd_pwr    = 150;
  int turn_pwr   = 120;
  int near_limit = 30;
  int tol_limit  = 50;
  int card[odc_pkg::NUM_CARD] = '{0, 900, -1800, -900};
  int mode_now   = MODE_STRAIGHT;
  int near_run   = 0;
  int goal_now   = 0;

  motor_cmd_t cmd_expect_q[$];
  int mismatches = 0;
  int cycles = 0;
  bit quiet = 1'b0;
  int stall_left = 0;

  function automatic int wrap_tenths(input int a);
    int r;
    r = a;
    while (r >= HALF_TENTHS) r -= FULL_TENTHS;
    while (r < -HALF_TENTHS) r += FULL_TENTHS;
    return r;
  endfunction

  function automatic int abs_int(input int a);
    return (a < 0) ? -a : a;
  endfunction

  function automatic void encode_motor(input int p, input bit is_left, output logic in1,
                                       output logic in2,
                                       output logic [odc_pkg::POWER_W-1:0] pwm);
    int m;
    m = -p;
    if (p > 0) begin
      in1 = !is_left;
      in2 = is_left;
      pwm = p[odc_pkg::POWER_W-1:0];
    end else if (p < 0) begin
      in1 = is_left;
      in2 = !is_left;
      pwm = m[odc_pkg::POWER_W-1:0];
    end else begin
      in1 = 1'b1;
      in2 = 1'b1;
      pwm = '0;
    end
  endfunction

  function automatic motor_cmd_t predict_tick(input reading_t r);
    motor_cmd_t o;
    int lp, rp, t, hdg, i;
    bit snapped;
    o = '0;
    hdg = int'($signed(r.heading));
    if (mode_now == MODE_STRAIGHT) begin
      lp = fwd_pwr;
      rp = lp;
      if (int'(r.front) < near_limit) begin
        if (near_run < NEAR_SAT) near_run++;
      end else begin
        near_run = 0;
      end
      if (near_run > odc_pkg::FILTER_LIMIT) begin
        lp = 0;
        rp = 0;
        if (r.right > r.left) begin
          t = wrap_tenths(hdg + QUARTER_TENTHS);
          mode_now = MODE_RIGHT;
        end else begin
          t = wrap_tenths(hdg - QUARTER_TENTHS);
          mode_now = MODE_LEFT;
        end
        snapped = 1'b0;
        for (i = 0; i < odc_pkg::SNAP_COUNT; i++) begin
          if (!snapped && abs_int(wrap_tenths(t - card[i])) <= SNAP_TENTHS) begin
            t = card[i];
            snapped = 1'b1;
          end
        end
        goal_now = t;
        near_run = 0;
        o.obstacle_seen = 1'b1;
      end
    end else begin
      lp = (mode_now > 0) ? turn_pwr : -turn_pwr;
      rp = -lp;
      if (abs_int(wrap_tenths(hdg - goal_now)) < tol_limit) begin
        lp = 0;
        rp = 0;
        mode_now = MODE_STRAIGHT;
        o.turn_done = 1'b1;
      end
    end
    encode_motor(lp, 1'b1, o.left_pin_a, o.left_pin_b, o.left_duty);
    encode_motor(rp, 1'b0, o.right_pin_a, o.right_pin_b, o.right_duty);
    o.drive_mode = mode_now[1:0];
    o.goal_heading = goal_now[odc_pkg::ANGLE_W-1:0];
    return o;
  endfunction

  function automatic string fmt_cmd(input motor_cmd_t c);
    return $sformatf("L %b%b/%0d R %b%b/%0d mode %0d goal %0d seen %b done %b",
                     c.left_pin_a, c.left_pin_b, c.left_duty, c.right_pin_a,
                     c.right_pin_b, c.right_duty, c.drive_mode, c.goal_heading,
                     c.obstacle_seen, c.turn_done);
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  always @(negedge clk) begin
    if (rst || quiet) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 4) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    motor_cmd_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = {left_pin_a, left_pin_b, left_duty, right_pin_a, right_pin_b, right_duty,
             drive_mode, goal_heading, obstacle_seen, turn_done};
      if (cmd_expect_q.size() == 0) begin
        flag_mismatch({"unexpected result ", fmt_cmd(got)});
      end else begin
        want = cmd_expect_q.pop_front();
        if (got.left_pin_a !== want.left_pin_a || got.left_pin_b !== want.left_pin_b ||
            got.left_duty !== want.left_duty || got.right_pin_a !== want.right_pin_a ||
            got.right_pin_b !== want.right_pin_b || got.right_duty !== want.right_duty ||
            got.drive_mode !== want.drive_mode || got.goal_heading !== want.goal_heading ||
            got.obstacle_seen !== want.obstacle_seen || got.turn_done !== want.turn_done)
        begin
          flag_mismatch({"expected ", fmt_cmd(want), " got ", fmt_cmd(got)});
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout with %0d results pending", cmd_expect_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_reading(input reading_t r);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    front_dist <= r.front;
    left_dist <= r.left;
    right_dist <= r.right;
    heading <= r.heading;
    do @(posedge clk); while (in_stall);
    cmd_expect_q.push_back(predict_tick(r));
  endtask

  task automatic send_fields(input int f, input int l, input int rt, input int h);
    reading_t r;
    r.front = f[odc_pkg::DIST_W-1:0];
    r.left = l[odc_pkg::DIST_W-1:0];
    r.right = rt[odc_pkg::DIST_W-1:0];
    r.heading = h[odc_pkg::ANGLE_W-1:0];
    send_reading(r);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (cmd_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input int fwd, input int turn, input int obst, input int tol,
                            input int c0, input int c1, input int c2, input int c3);
    int vals[8];
    logic [odc_pkg::ANGLE_W-1:0] bits;
    odc_pkg::reg_index_t idx;
    vals = '{fwd, turn, obst, tol, c0, c1, c2, c3};
    for (int i = 0; i < 8; i++) begin
      idx = odc_pkg::reg_index_t'(i);
      bits = vals[i][odc_pkg::ANGLE_W-1:0];
      @(negedge clk);
      wr_en <= 1'b1;
      wr_index <= idx;
      wr_data <= bits;
      @(posedge clk);
      case (idx)
        odc_pkg::REG_CRUISE_PWR:  fwd_pwr = int'(bits[odc_pkg::POWER_W-1:0]);
        odc_pkg::REG_SPIN_PWR:    turn_pwr = int'(bits[odc_pkg::POWER_W-1:0]);
        odc_pkg::REG_NEAR_THRESH: near_limit = int'(bits[odc_pkg::DIST_W-1:0]);
        odc_pkg::REG_ANGLE_TOL:   tol_limit = int'(bits[odc_pkg::TOL_W-1:0]);
        odc_pkg::REG_CARDINAL_0:  card[0] = int'($signed(bits));
        odc_pkg::REG_CARDINAL_1:  card[1] = int'($signed(bits));
        odc_pkg::REG_CARDINAL_2:  card[2] = int'($signed(bits));
        odc_pkg::REG_CARDINAL_3:  card[3] = int'($signed(bits));
        default: ;
      endcase
    end
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic random_config(input bit wild_cards);
    if (wild_cards) begin
      set_config($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(1, 300),
                 $urandom_range(0, 400), int'($urandom_range(0, 4095)) - 2048,
                 int'($urandom_range(0, 4095)) - 2048, int'($urandom_range(0, 4095)) - 2048,
                 int'($urandom_range(0, 4095)) - 2048);
    end else begin
      set_config($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(1, 300),
                 $urandom_range(0, 400), int'($urandom_range(0, 3599)) - 1800,
                 int'($urandom_range(0, 3599)) - 1800, int'($urandom_range(0, 3599)) - 1800,
                 int'($urandom_range(0, 3599)) - 1800);
    end
  endtask

  // mostly near-obstacle runs and headings that close in on the goal, some noise
  function automatic reading_t pick_reading();
    reading_t r;
    int span, h;
    r.front = odc_pkg::DIST_W'($urandom_range(0, 1023));
    r.left = odc_pkg::DIST_W'($urandom_range(0, 1023));
    r.right = odc_pkg::DIST_W'($urandom_range(0, 1023));
    r.heading = odc_pkg::ANGLE_W'($urandom_range(0, 4095));
    if ($urandom_range(0, 99) < 15) return r;
    if (mode_now == MODE_STRAIGHT) begin
      if (near_limit > 0 && $urandom_range(0, 4) != 0) begin
        r.front = odc_pkg::DIST_W'($urandom_range(0, near_limit - 1));
      end else begin
        r.front = odc_pkg::DIST_W'($urandom_range(near_limit, 1023));
      end
      if ($urandom_range(0, 7) == 0) r.right = r.left;
      h = int'($urandom_range(0, 3599)) - HALF_TENTHS;
    end else begin
      span = tol_limit + 30;
      h = goal_now + int'($urandom_range(0, 2 * span)) - span;
      if ($urandom_range(0, 3) == 0) h = h + int'($urandom_range(0, 1200)) - 600;
      h = wrap_tenths(h);
    end
    r.heading = h[odc_pkg::ANGLE_W-1:0];
    return r;
  endfunction

  task automatic send_random(input int count);
    repeat (count) send_reading(pick_reading());
  endtask

  task automatic test_obstacle_turns();
    send_fields(1023, 0, 1023, 0);
    send_fields(0, 0, 0, -2048);
    send_fields(29, 1023, 0, 2047);
    send_fields(30, 5, 6, 100);
    send_fields(0, 0, 0, 100);
    send_fields(0, 5, 6, 100);
    send_fields(0, 100, 200, 100);
    send_fields(0, 100, 200, 100);
    send_fields(0, 100, 200, 0);
    send_fields(1023, 1023, 1023, 850);
    send_fields(5, 5, 5, 851);
    send_fields(0, 500, 500, 2047);
    send_fields(0, 500, 500, 2047);
    send_fields(0, 500, 500, 2047);
    send_fields(0, 500, 500, -2048);
    send_fields(0, 1023, 0, 2047);
    send_fields(0, 0, 1023, 900);
    wait_drained();
  endtask

  task automatic test_zero_power();
    set_config(0, 0, 30, 50, 0, 900, -1800, -900);
    send_fields(512, 7, 9, -1);
    repeat (4) send_fields(1, 0, 1023, -1800);
    send_fields(0, 0, 0, -1800);
    send_fields(0, 0, 0, -900);
    wait_drained();
  endtask

  task automatic test_snap_edges();
    set_config(200, 80, 1023, 1, 2047, -2048, 1799, -1800);
    repeat (4) send_fields(1022, 300, 301, 1000);
    send_fields(1022, 0, 0, 1900);
    repeat (4) send_fields(0, 1, 0, -700);
    send_fields(0, 0, 0, -1600);
    wait_drained();
  endtask

  task automatic test_config_sweep();
    set_config(255, 255, 1023, 1800, 0, 900, -1800, -900);
    send_random(60);
    wait_drained();
    set_config(1, 1, 0, 0, 0, 900, -1800, -900);
    send_random(40);
    wait_drained();
    set_config(128, 64, 500, 1, -450, 450, 1350, -1350);
    send_random(60);
    wait_drained();
    repeat (4) begin
      random_config(1'b1);
      send_random(50);
      wait_drained();
    end
  endtask

  task automatic test_random_traffic();
    set_config(150, 120, 30, 50, 0, 900, -1800, -900);
    send_random(200);
    wait_drained();
    repeat (3) begin
      random_config(1'b0);
      send_random(60);
      wait_drained();
    end
  endtask

  task automatic test_quiet_tail();
    quiet = 1'b1;
    random_config(1'b0);
    send_random(80);
    wait_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_obstacle_turns();
    test_zero_power();
    test_snap_edges();
    test_config_sweep();
    test_random_traffic();
    test_quiet_tail();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
